FILE: rtl/core/caldate_pkg.sv
// Shared types, constants and table functions of the calendar date counter.
`timescale 1ns / 1ps
package caldate_pkg;

   localparam int unsigned DAY_W   = 5;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned WDAY_W  = 3;
   localparam int unsigned YLO_W   = 7;
   localparam int unsigned QUOT_W  = 12;
   localparam int unsigned RECIP_W = 13;
   localparam int unsigned PROD_W  = QUOT_W + RECIP_W;
   localparam int unsigned CENT_W  = 8;
   localparam int unsigned MTERM_W = 5;

   localparam logic [RECIP_W-1:0] RECIP_25     = RECIP_W'(5243);
   localparam int unsigned        RECIP_SHIFT  = 17;
   localparam logic [YEAR_W-1:0]  YEAR_MIN     = YEAR_W'(1);
   localparam logic [YEAR_W-1:0]  YEAR_MAX     = YEAR_W'(9999);
   localparam logic [MONTH_W-1:0] MONTH_JAN    = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_FEB    = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_DEC    = MONTH_W'(12);
   localparam logic [DAY_W-1:0]   DAY_FIRST    = DAY_W'(1);
   localparam logic [DAY_W-1:0]   DAY_LAST_DEC = DAY_W'(31);
   localparam logic [YLO_W-1:0]   YLO_LAST     = YLO_W'(99);
   localparam logic [WDAY_W-1:0]  WDAY_FRI     = WDAY_W'(5);
   localparam logic [WDAY_W-1:0]  WDAY_SAT     = WDAY_W'(6);

   typedef enum logic {
      ACT_TICK = 1'b0,
      ACT_LOAD = 1'b1
   } action_type;

   typedef struct packed {
      logic                action;
      logic [DAY_W-1:0]    load_day;
      logic [MONTH_W-1:0]  load_month;
      logic [YEAR_W-1:0]   load_year;
      logic [PROD_W-1:0]   year_prod;
   } load_word_type;

   typedef struct packed {
      logic [DAY_W-1:0]    day;
      logic [MONTH_W-1:0]  month;
      logic [YEAR_W-1:0]   year;
      logic                load_rejected;
      logic                at_limit;
   } date_word_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd2:                      len = leap ? DAY_W'(29) : DAY_W'(28);
         4'd4, 4'd6, 4'd9, 4'd11:   len = DAY_W'(30);
         default:                   len = DAY_W'(31);
      endcase
      return len;
   endfunction

   // (31 * mm) / 12 for the shifted month, March = 1 .. February = 12
   function automatic logic [MTERM_W-1:0] month_term(input logic [MONTH_W-1:0] mm);
      logic [MTERM_W-1:0] t;
      case (mm)
         4'd1:    t = MTERM_W'(2);
         4'd2:    t = MTERM_W'(5);
         4'd3:    t = MTERM_W'(7);
         4'd4:    t = MTERM_W'(10);
         4'd5:    t = MTERM_W'(12);
         4'd6:    t = MTERM_W'(15);
         4'd7:    t = MTERM_W'(18);
         4'd8:    t = MTERM_W'(20);
         4'd9:    t = MTERM_W'(23);
         4'd10:   t = MTERM_W'(25);
         4'd11:   t = MTERM_W'(28);
         4'd12:   t = MTERM_W'(31);
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

FILE: rtl/core/caldate_ifs.sv
// Request and response channel interfaces of the calendar date counter.
`timescale 1ns / 1ps
interface caldate_req_if;
   logic                               valid;
   logic                               ready;
   logic                               action;
   logic [caldate_pkg::DAY_W-1:0]      load_day;
   logic [caldate_pkg::MONTH_W-1:0]    load_month;
   logic [caldate_pkg::YEAR_W-1:0]     load_year;

   modport source (output valid, action, load_day, load_month, load_year, input ready);
   modport sink   (input valid, action, load_day, load_month, load_year, output ready);
endinterface

interface caldate_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [caldate_pkg::DAY_W-1:0]      day;
   logic [caldate_pkg::MONTH_W-1:0]    month;
   logic [caldate_pkg::YEAR_W-1:0]     year;
   logic [caldate_pkg::WDAY_W-1:0]     day_of_week;
   logic                               weekend;
   logic                               load_rejected;
   logic                               at_limit;

   modport source (output valid, day, month, year, day_of_week, weekend, load_rejected,
                   at_limit, input ready);
   modport sink   (input valid, day, month, year, day_of_week, weekend, load_rejected,
                   at_limit, output ready);
endinterface

FILE: rtl/core/caldate_in_reg.sv
// Input register stage: captures a transaction and starts the load year split by 100.
`timescale 1ns / 1ps
module caldate_in_reg (
   input  logic                        clock,
   input  logic                        reset,
   caldate_req_if.sink                 req_bus,
   output logic                        out_valid,
   input  logic                        out_ready,
   output caldate_pkg::load_word_type  out_word
);
   import caldate_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   load_word_type word_ff;
   load_word_type word_in;
   logic          take;

   assign req_bus.ready = !valid_ff || out_ready;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
      word_in            = word_ff;
      word_in.action     = req_bus.action;
      word_in.load_day   = req_bus.load_day;
      word_in.load_month = req_bus.load_month;
      word_in.load_year  = req_bus.load_year;
      word_in.year_prod  = PROD_W'(req_bus.load_year[YEAR_W-1:2]) * PROD_W'(RECIP_25);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

FILE: rtl/core/caldate_date_core.sv
// Date state stage: validates loads, advances the date on ticks and registers the result.
`timescale 1ns / 1ps
module caldate_date_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  caldate_pkg::load_word_type  in_word,
   output logic                        out_valid,
   input  logic                        out_ready,
   output caldate_pkg::date_word_type  out_word
);
   import caldate_pkg::*;

   logic [DAY_W-1:0]   day_ff,   day_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [YEAR_W-1:0]  year_ff,  year_in;
   logic [YLO_W-1:0]   ylo_ff,   ylo_in;
   logic [1:0]         cent_ff,  cent_in;
   logic               valid_ff, valid_in;
   date_word_type      word_ff,  word_in;

   logic               take;
   logic [CENT_W-1:0]  ld_cent;
   logic [YEAR_W-1:0]  ld_cent_x100;
   logic [YEAR_W-1:0]  ld_rem_full;
   logic [YLO_W-1:0]   ld_rem;
   logic               ld_leap;
   logic               ld_ok;
   logic               cur_leap;
   logic               rejected;
   logic               limit;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      ld_cent      = in_word.year_prod[PROD_W-1:RECIP_SHIFT];
      ld_cent_x100 = (YEAR_W'(ld_cent) << 6) + (YEAR_W'(ld_cent) << 5)
                   + (YEAR_W'(ld_cent) << 2);
      ld_rem_full  = in_word.load_year - ld_cent_x100;
      ld_rem       = ld_rem_full[YLO_W-1:0];
      ld_leap      = (ld_rem == '0) ? (ld_cent[1:0] == 2'd0)
                                    : (in_word.load_year[1:0] == 2'd0);
      ld_ok        = (in_word.load_month >= MONTH_JAN) && (in_word.load_month <= MONTH_DEC)
                  && (in_word.load_year >= YEAR_MIN) && (in_word.load_year <= YEAR_MAX)
                  && (in_word.load_day >= DAY_FIRST)
                  && (in_word.load_day <= month_len(in_word.load_month, ld_leap));
      cur_leap     = (ylo_ff == '0) ? (cent_ff == 2'd0) : (year_ff[1:0] == 2'd0);

      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      ylo_in   = ylo_ff;
      cent_in  = cent_ff;
      rejected = 1'b0;
      limit    = 1'b0;

      if (in_word.action == ACT_LOAD) begin
         if (ld_ok) begin
            day_in   = in_word.load_day;
            month_in = in_word.load_month;
            year_in  = in_word.load_year;
            ylo_in   = ld_rem;
            cent_in  = ld_cent[1:0];
         end else begin
            rejected = 1'b1;
         end
      end else if (day_ff == DAY_LAST_DEC && month_ff == MONTH_DEC && year_ff >= YEAR_MAX) begin
         limit = 1'b1;
      end else if (day_ff >= month_len(month_ff, cur_leap)) begin
         day_in = DAY_FIRST;
         if (month_ff >= MONTH_DEC) begin
            month_in = MONTH_JAN;
            year_in  = year_ff + YEAR_W'(1);
            if (ylo_ff == YLO_LAST) begin
               ylo_in  = '0;
               cent_in = cent_ff + 2'd1;
            end else begin
               ylo_in  = ylo_ff + YLO_W'(1);
            end
         end else begin
            month_in = month_ff + MONTH_W'(1);
         end
      end else begin
         day_in = day_ff + DAY_W'(1);
      end

      word_in.day           = day_in;
      word_in.month         = month_in;
      word_in.year          = year_in;
      word_in.load_rejected = rejected;
      word_in.at_limit      = limit;

      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff   <= DAY_FIRST;
         month_ff <= MONTH_JAN;
         year_ff  <= YEAR_MIN;
         ylo_ff   <= YLO_W'(1);
         cent_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            day_ff   <= day_in;
            month_ff <= month_in;
            year_ff  <= year_in;
            ylo_ff   <= ylo_in;
            cent_ff  <= cent_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

FILE: rtl/core/caldate_weekday.sv
// Weekday stages: split the shifted year by 100, then sum the terms modulo 7 into the response.
`timescale 1ns / 1ps
module caldate_weekday (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  caldate_pkg::date_word_type  in_word,
   caldate_rsp_if.source               rsp_bus
);
   import caldate_pkg::*;

   localparam int unsigned SUM_W = YEAR_W + 1;

   logic                 mid_valid_ff, mid_valid_in;
   date_word_type        mid_word_ff;
   logic [YEAR_W-1:0]    mid_yy_ff,    mid_yy_in;
   logic [PROD_W-1:0]    mid_prod_ff,  mid_prod_in;
   logic [MTERM_W-1:0]   mid_term_ff,  mid_term_in;
   logic                 mid_ready;
   logic                 mid_take;
   logic                 early;
   logic [MONTH_W-1:0]   mm;

   logic                 out_valid_ff, out_valid_in;
   date_word_type        out_word_ff;
   logic [WDAY_W-1:0]    out_wday_ff,  out_wday_in;
   logic                 out_take;
   logic [CENT_W-1:0]    cent;
   logic [SUM_W-1:0]     total;
   logic [5:0]           fold1;
   logic [3:0]           fold2;
   logic [3:0]           wrap;

   assign in_ready  = !mid_valid_ff || mid_ready;
   assign mid_take  = in_valid && in_ready;
   assign mid_ready = !out_valid_ff || rsp_bus.ready;
   assign out_take  = mid_valid_ff && mid_ready;

   always_comb begin
      early       = (in_word.month <= MONTH_FEB);
      mid_yy_in   = in_word.year - YEAR_W'(early);
      mm          = early ? (in_word.month + MONTH_W'(10)) : (in_word.month - MONTH_FEB);
      mid_prod_in = PROD_W'(mid_yy_in[YEAR_W-1:2]) * PROD_W'(RECIP_25);
      mid_term_in = month_term(mm);

      mid_valid_in = mid_valid_ff;
      if (mid_take) begin
         mid_valid_in = 1'b1;
      end else if (mid_ready) begin
         mid_valid_in = 1'b0;
      end
   end

   always_comb begin
      cent  = mid_prod_ff[PROD_W-1:RECIP_SHIFT];
      total = SUM_W'(mid_word_ff.day) + SUM_W'(mid_yy_ff) + SUM_W'(mid_yy_ff[YEAR_W-1:2])
            - SUM_W'(cent) + SUM_W'(cent[CENT_W-1:2]) + SUM_W'(mid_term_ff);
      fold1 = 6'(total[14:12]) + 6'(total[11:9]) + 6'(total[8:6])
            + 6'(total[5:3]) + 6'(total[2:0]);
      fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
      wrap  = (fold2 >= 4'd7) ? (fold2 - 4'd7) : fold2;
      out_wday_in = wrap[WDAY_W-1:0];

      out_valid_in = out_valid_ff;
      if (out_take) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_take) begin
         mid_word_ff <= in_word;
         mid_yy_ff   <= mid_yy_in;
         mid_prod_ff <= mid_prod_in;
         mid_term_ff <= mid_term_in;
      end
      if (out_take) begin
         out_word_ff <= mid_word_ff;
         out_wday_ff <= out_wday_in;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.day           = out_word_ff.day;
   assign rsp_bus.month         = out_word_ff.month;
   assign rsp_bus.year          = out_word_ff.year;
   assign rsp_bus.day_of_week   = out_wday_ff;
   assign rsp_bus.weekend       = (out_wday_ff == WDAY_FRI) || (out_wday_ff == WDAY_SAT);
   assign rsp_bus.load_rejected = out_word_ff.load_rejected;
   assign rsp_bus.at_limit      = out_word_ff.at_limit;

endmodule

FILE: rtl/core/calendar_date_counter_top.sv
// Top level of the calendar date counter.
//
//  Channel   Direction  Transaction
//  req_bus   in         tick or load (action, load_day, load_month, load_year)
//  rsp_bus   out        date after the step, weekday, weekend, load_rejected, at_limit
//
//  One transaction per cycle sustained while rsp_bus is ready; four register stages (input,
//  date, weekday split, response) lie between a request and its response.
//  The date register stage closes the only feedback loop, one date update per transaction.
//  Reset sets the date to 1 Jan year 1 and empties all stages.
//  A stalled response holds its stage; earlier stages keep filling until every stage is full.
`timescale 1ns / 1ps
module calendar_date_counter_top (
   input  logic           clock,
   input  logic           reset,
   caldate_req_if.sink    req_bus,
   caldate_rsp_if.source  rsp_bus
);
   import caldate_pkg::*;

   logic          s1_valid;
   logic          s1_ready;
   load_word_type s1_word;
   logic          s2_valid;
   logic          s2_ready;
   date_word_type s2_word;

   caldate_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_word  (s1_word)
   );

   caldate_date_core u_date_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_word   (s1_word),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_word  (s2_word)
   );

   caldate_weekday u_weekday (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s2_valid),
      .in_ready (s2_ready),
      .in_word  (s2_word),
      .rsp_bus  (rsp_bus)
   );

endmodule

FILE: rtl/core/caldate_chk.sv
// Port checker of the calendar date counter and its bind to the top level.
`timescale 1ns / 1ps
module caldate_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [caldate_pkg::DAY_W-1:0]     rsp_day,
   input logic [caldate_pkg::MONTH_W-1:0]   rsp_month,
   input logic [caldate_pkg::YEAR_W-1:0]    rsp_year,
   input logic [caldate_pkg::WDAY_W-1:0]    rsp_day_of_week,
   input logic                              rsp_weekend,
   input logic                              rsp_load_rejected,
   input logic                              rsp_at_limit
);
   import caldate_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_day) && $stable(rsp_month)
                                  && $stable(rsp_year) && $stable(rsp_day_of_week))
      else $error("response changed while stalled");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_day >= DAY_FIRST && rsp_day <= DAY_LAST_DEC
                    && rsp_month >= MONTH_JAN && rsp_month <= MONTH_DEC
                    && rsp_year >= YEAR_MIN && rsp_year <= YEAR_MAX)
      else $error("date out of range");

   a_wday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_day_of_week <= WDAY_SAT)
      else $error("weekday out of range");

   a_weekend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_weekend == (rsp_day_of_week == WDAY_FRI
                                    || rsp_day_of_week == WDAY_SAT))
      else $error("weekend flag disagrees with weekday");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_load_rejected && rsp_at_limit))
      else $error("reject and limit both set");

endmodule

bind calendar_date_counter_top caldate_chk u_caldate_chk (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_day           (rsp_bus.day),
   .rsp_month         (rsp_bus.month),
   .rsp_year          (rsp_bus.year),
   .rsp_day_of_week   (rsp_bus.day_of_week),
   .rsp_weekend       (rsp_bus.weekend),
   .rsp_load_rejected (rsp_bus.load_rejected),
   .rsp_at_limit      (rsp_bus.at_limit)
);
